// ===== src/vmt_pkg.sv =====
// Shared types and constants for the vertex matrix transform unit.
package vmt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_REGS      = 8;
  localparam int REG_IDX_W     = 3;
  localparam int ADDR_W        = REG_IDX_W + 3;
  localparam int DATA_W        = 64;

  // Identity matrix at reset
  localparam logic [DATA_W-1:0] REG_RESET [0:NUM_REGS-1] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

  typedef struct packed {
    logic              opcode;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } vmt_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic              divisor_zero;
    logic              overflowed;
  } vmt_out_t;

endpackage

// ===== src/vmt_div.sv =====
// One component lane: signed fixed-point divide by w, one quotient bit per stage, saturated.
module vmt_div import vmt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            valid_in,
  input  logic signed [65-FRAC_BITS:0]    acc,
  input  logic                            den_neg,
  input  logic [65-FRAC_BITS:0]           den_mag,
  input  logic                            den_zero,
  output logic                            valid_out,
  output logic signed [31:0]              quot,
  output logic                            ovf,
  output logic                            zero_out
);

  localparam int ACC_W = 66 - FRAC_BITS;
  localparam int NW    = ACC_W + FRAC_BITS;
  localparam int QB    = 33;

  // entry stage
  logic             s0_valid, s0_neg, s0_wz, s0_bov;
  logic [ACC_W-1:0] s0_un, s0_ud;
  logic [31:0]      s0_byp;
  logic [ACC_W-1:0] acc_mag;
  logic             acc_fits;
  logic [NW-1:0]    num;

  // division stages
  logic [ACC_W-1:0] r   [0:QB];
  logic [QB-1:0]    lo  [0:QB];
  logic [QB-1:0]    q   [0:QB];
  logic             v   [0:QB];
  logic             sn  [0:QB];
  logic             big [0:QB];
  logic             wz  [0:QB];
  logic             bov [0:QB];
  logic [31:0]      byp [0:QB];

  // divisor carried alongside each stage
  logic [ACC_W-1:0] ud_p [0:QB];

  logic [ACC_W:0]   t   [0:QB-1];
  logic             ge  [0:QB-1];

  logic [QB-1:0]    qf;
  logic             sat;
  logic [31:0]      qval;

  always_comb begin
    acc_mag  = acc[ACC_W-1] ? (~acc + 1'b1) : acc;
    acc_fits = (&acc[ACC_W-1:31]) | ~(|acc[ACC_W-1:31]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= valid_in;
    end
    s0_neg <= acc[ACC_W-1] ^ den_neg;
    s0_un  <= acc_mag;
    s0_ud  <= den_mag;
    s0_wz  <= den_zero;
    s0_bov <= ~acc_fits;
    if (acc_fits) begin
      s0_byp <= acc[31:0];
    end else if (acc[ACC_W-1]) begin
      s0_byp <= 32'h8000_0000;
    end else begin
      s0_byp <= 32'h7FFF_FFFF;
    end
  end

  assign num = {s0_un, {FRAC_BITS{1'b0}}};

  always_comb begin
    for (int j = 0; j < QB; j++) begin
      t[j]  = {r[j], lo[j][QB-1]};
      ge[j] = t[j] >= {1'b0, ud_p[j]};
    end
  end

  // load the partial remainder with the top of the scaled numerator, then
  // resolve one quotient bit per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= s0_valid;
    end
    big[0]  <= ACC_W'(num[NW-1:QB]) >= s0_ud;
    r[0]    <= ACC_W'(num[NW-1:QB]);
    lo[0]   <= num[QB-1:0];
    q[0]    <= '0;
    sn[0]   <= s0_neg;
    wz[0]   <= s0_wz;
    bov[0]  <= s0_bov;
    byp[0]  <= s0_byp;
    ud_p[0] <= s0_ud;
    for (int j = 0; j < QB; j++) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else begin
        v[j+1] <= v[j];
      end
      r[j+1]    <= ge[j] ? ACC_W'(t[j] - {1'b0, ud_p[j]}) : t[j][ACC_W-1:0];
      lo[j+1]   <= {lo[j][QB-2:0], 1'b0};
      q[j+1]    <= {q[j][QB-2:0], ge[j]};
      sn[j+1]   <= sn[j];
      big[j+1]  <= big[j];
      wz[j+1]   <= wz[j];
      bov[j+1]  <= bov[j];
      byp[j+1]  <= byp[j];
      ud_p[j+1] <= ud_p[j];
    end
  end

  always_comb begin
    qf = q[QB];
    if (sn[QB]) begin
      sat  = big[QB] | qf[32] | (qf[31] & (|qf[30:0]));
      qval = sat ? 32'h8000_0000 : (~qf[31:0] + 1'b1);
    end else begin
      sat  = big[QB] | qf[32] | qf[31];
      qval = sat ? 32'h7FFF_FFFF : qf[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= v[QB];
    end
    zero_out <= wz[QB];
    if (wz[QB]) begin
      quot <= byp[QB];
      ovf  <= bov[QB];
    end else begin
      quot <= qval;
      ovf  <= sat;
    end
  end

endmodule

// ===== src/vertex_matrix_transform_unit.sv =====
// Top level of the vertex matrix transform unit: matrix registers, multiply-sum and divide lanes.
//
// Takes one vertex per clock with busy never raised, and gives one result per
// vertex on a one-cycle done strobe. A vertex passes through the
// three multiply-and-sum stages and then the divide lanes, which resolve one
// quotient bit per stage (33 bits) between an entry stage, a load stage and a
// saturating output stage. The matrix must be written only while no vertex is
// in flight, and the receiver must take every result in the cycle it appears.
module vertex_matrix_transform_unit import vmt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  vmt_in_t           item,
  output logic              done,
  output vmt_out_t          result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int ACC_W = 66 - FRAC_BITS;
  localparam int PW    = 64 - FRAC_BITS;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  logic [DATA_W-1:0] cfg [0:NUM_REGS-1];
  logic signed [31:0] m [0:3][0:3];

  logic               a_valid;
  logic signed [63:0] a_p [0:2][0:3];
  logic signed [31:0] a_t [0:3];
  logic signed [31:0] vin [0:2];

  logic               b_valid;
  logic signed [ACC_W-1:0] b_s01 [0:3];
  logic signed [ACC_W-1:0] b_s23 [0:3];
  logic signed [63:0]      ps    [0:2][0:3];
  logic signed [PW-1:0]    rp    [0:2][0:3];

  logic               c_valid;
  logic signed [ACC_W-1:0] c_acc [0:3];

  logic               den_neg, den_zero;
  logic [ACC_W-1:0]   den_mag;

  logic               lane_valid [0:2];
  logic signed [31:0] lane_q     [0:2];
  logic               lane_ovf   [0:2];
  logic               lane_zero  [0:2];

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = cfg[paddr[ADDR_W-1:3]];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg[i] <= REG_RESET[i];
      end
    end else if (psel && penable && pwrite) begin
      cfg[paddr[ADDR_W-1:3]] <= pwdata;
    end
  end

  always_comb begin
    for (int rr = 0; rr < 4; rr++) begin
      for (int cc = 0; cc < 4; cc++) begin
        m[rr][cc] = cfg[rr*2 + cc/2][(cc%2)*32 +: 32];
      end
    end
    vin[0] = item.in_x;
    vin[1] = item.in_y;
    vin[2] = item.in_z;
  end

  // products; the fourth row uses the entry as is, or zero when opcode is set
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start;
    end
    for (int rr = 0; rr < 3; rr++) begin
      for (int cc = 0; cc < 4; cc++) begin
        a_p[rr][cc] <= vin[rr] * m[rr][cc];
      end
    end
    for (int cc = 0; cc < 4; cc++) begin
      a_t[cc] <= item.opcode ? 32'sd0 : m[3][cc];
    end
  end

  always_comb begin
    for (int rr = 0; rr < 3; rr++) begin
      for (int cc = 0; cc < 4; cc++) begin
        ps[rr][cc] = a_p[rr][cc] + HALF;
        rp[rr][cc] = PW'(ps[rr][cc] >>> FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
    for (int cc = 0; cc < 4; cc++) begin
      b_s01[cc] <= ACC_W'(rp[0][cc]) + ACC_W'(rp[1][cc]);
      b_s23[cc] <= ACC_W'(rp[2][cc]) + ACC_W'(a_t[cc]);
      c_acc[cc] <= b_s01[cc] + b_s23[cc];
    end
  end

  always_comb begin
    den_neg  = c_acc[3][ACC_W-1];
    den_zero = ~(|c_acc[3]);
    den_mag  = den_neg ? (~c_acc[3] + 1'b1) : c_acc[3];
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    vmt_div #(
      .FRAC_BITS(FRAC_BITS)
    ) u_div (
      .clk      (clk),
      .rst      (rst),
      .valid_in (c_valid),
      .acc      (c_acc[g]),
      .den_neg  (den_neg),
      .den_mag  (den_mag),
      .den_zero (den_zero),
      .valid_out(lane_valid[g]),
      .quot     (lane_q[g]),
      .ovf      (lane_ovf[g]),
      .zero_out (lane_zero[g])
    );
  end

  always_comb begin
    done                = lane_valid[0] & lane_valid[1] & lane_valid[2];
    result.out_x        = lane_q[0];
    result.out_y        = lane_q[1];
    result.out_z        = lane_q[2];
    result.divisor_zero = lane_zero[0] | lane_zero[1] | lane_zero[2];
    result.overflowed   = lane_ovf[0] | lane_ovf[1] | lane_ovf[2];
  end

endmodule
